>>> rtl/h264d_pkg.sv
// ----------------------------------------------------------------------------
// H.264 RTP depacketizer package
// Shared types, constants and helpers for the depacketizer blocks.
// ----------------------------------------------------------------------------
`default_nettype none

package h264d_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic [4:0] NAL_TYPE_MIN = 5'd1;
    localparam logic [4:0] NAL_TYPE_MAX = 5'd23;
    localparam logic [4:0] TYPE_STAP_A  = 5'd24;
    localparam logic [4:0] TYPE_FU_A    = 5'd28;

    localparam logic LANE_DIRECT = 1'b0;
    localparam logic LANE_FRAG   = 1'b1;

    typedef struct packed {
        logic [7:0] nal_byte;
        logic       has_byte;
        logic       nal_first;
        logic       nal_last;
        logic       nal_discard;
        logic       fragment_lane;
    } t_nal;

    typedef struct packed {
        logic two;
        t_nal r0;
        t_nal r1;
    } t_entry;

    localparam t_nal NAL_NONE = '0;

    function automatic t_nal mk_nal(input logic [7:0] b, input logic has,
                                    input logic first, input logic last,
                                    input logic disc, input logic lane);
        t_nal r;
        r.nal_byte      = b;
        r.has_byte      = has;
        r.nal_first     = first;
        r.nal_last      = last;
        r.nal_discard   = disc;
        r.fragment_lane = lane;
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/h264d_if.sv
// ----------------------------------------------------------------------------
// H.264 RTP depacketizer channels
// Payload byte input channel and NAL byte output channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface h264d_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       payload_first;
    logic       payload_last;

    modport source (output valid, output payload_byte, output payload_first,
                    output payload_last, input ready);
    modport sink   (input valid, input payload_byte, input payload_first,
                    input payload_last, output ready);
endinterface

interface h264d_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] nal_byte;
    logic       has_byte;
    logic       nal_first;
    logic       nal_last;
    logic       nal_discard;
    logic       fragment_lane;

    modport source (output valid, output nal_byte, output has_byte, output nal_first,
                    output nal_last, output nal_discard, output fragment_lane,
                    input ready);
    modport sink   (input valid, input nal_byte, input has_byte, input nal_first,
                    input nal_last, input nal_discard, input fragment_lane,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/h264d_front.sv
// ----------------------------------------------------------------------------
// H.264 RTP depacketizer front end
// Accepts payload bytes, tracks payload framing and emits result entries.
// ----------------------------------------------------------------------------
`default_nettype none

module h264d_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    h264d_in_if.sink              i_in,
    input  wire logic             i_full,
    output h264d_pkg::t_entry     o_entry,
    output logic                  o_push
);
    import h264d_pkg::*;

    typedef enum logic [1:0] {K_IGNORE, K_SINGLE, K_STAP, K_FU} t_kind;
    typedef enum logic [1:0] {PH_HI, PH_LO, PH_BODY} t_phase;

    t_kind       r_kind, n_kind;
    logic [1:0]  r_pos, n_pos;
    logic        r_fu_open, n_fu_open;
    logic [2:0]  r_fu_ind, n_fu_ind;
    logic        r_fu_end, n_fu_end;
    t_phase      r_ph, n_ph;
    logic [15:0] r_rem, n_rem;
    logic        r_ao, n_ao;

    logic        accept;
    logic [1:0]  cnt;
    t_nal        res [2];

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        logic [7:0]  b;
        logic        first;
        logic        last;
        logic [4:0]  ntype;
        logic [15:0] rem_dec;
        b         = i_in.payload_byte;
        first     = i_in.payload_first;
        last      = i_in.payload_last;
        ntype     = b[4:0];
        rem_dec   = r_rem - 16'd1;
        n_kind    = r_kind;
        n_pos     = r_pos;
        n_fu_open = r_fu_open;
        n_fu_ind  = r_fu_ind;
        n_fu_end  = r_fu_end;
        n_ph      = r_ph;
        n_rem     = r_rem;
        n_ao      = r_ao;
        cnt       = 2'd0;
        res[0]    = NAL_NONE;
        res[1]    = NAL_NONE;
        if (first) begin
            if (r_kind == K_SINGLE || (r_kind == K_STAP && r_ao)) begin
                res[cnt[0]] = mk_nal(8'h00, 1'b0, 1'b0, 1'b0, 1'b1, LANE_DIRECT);
                cnt = cnt + 2'd1;
            end else if (r_kind == K_FU && r_fu_open) begin
                res[cnt[0]] = mk_nal(8'h00, 1'b0, 1'b0, 1'b0, 1'b1, LANE_FRAG);
                cnt = cnt + 2'd1;
                n_fu_open = 1'b0;
            end
            n_kind   = K_IGNORE;
            n_ph     = PH_HI;
            n_rem    = '0;
            n_ao     = 1'b0;
            n_fu_end = 1'b0;
            if (ntype >= NAL_TYPE_MIN && ntype <= NAL_TYPE_MAX) begin
                n_kind = K_SINGLE;
                res[cnt[0]] = mk_nal(b, 1'b1, 1'b1, last, 1'b0, LANE_DIRECT);
                cnt = cnt + 2'd1;
            end else if (ntype == TYPE_STAP_A) begin
                n_kind = K_STAP;
            end else if (ntype == TYPE_FU_A) begin
                n_kind   = K_FU;
                n_fu_ind = b[7:5];
            end
            n_pos = 2'd1;
        end else begin
            case (r_kind)
                K_SINGLE: begin
                    res[cnt[0]] = mk_nal(b, 1'b1, 1'b0, last, 1'b0, LANE_DIRECT);
                    cnt = cnt + 2'd1;
                end
                K_STAP: begin
                    case (r_ph)
                        PH_HI: begin
                            n_rem = {b, 8'h00};
                            n_ph  = PH_LO;
                        end
                        PH_LO: begin
                            n_rem = r_rem | {8'h00, b};
                            if (n_rem == 16'd0) begin
                                res[cnt[0]] = mk_nal(8'h00, 1'b0, 1'b1, 1'b1, 1'b0,
                                                     LANE_DIRECT);
                                cnt = cnt + 2'd1;
                                n_ph = PH_HI;
                            end else begin
                                n_ph = PH_BODY;
                                n_ao = 1'b0;
                            end
                        end
                        default: begin
                            n_rem = rem_dec;
                            if (rem_dec == 16'd0) begin
                                res[cnt[0]] = mk_nal(b, 1'b1, !r_ao, 1'b1, 1'b0,
                                                     LANE_DIRECT);
                                cnt = cnt + 2'd1;
                                n_ao = 1'b0;
                                n_ph = PH_HI;
                            end else if (last) begin
                                if (r_ao) begin
                                    res[cnt[0]] = mk_nal(8'h00, 1'b0, 1'b0, 1'b0, 1'b1,
                                                         LANE_DIRECT);
                                    cnt = cnt + 2'd1;
                                end
                                n_ao = 1'b0;
                            end else begin
                                res[cnt[0]] = mk_nal(b, 1'b1, !r_ao, 1'b0, 1'b0,
                                                     LANE_DIRECT);
                                cnt = cnt + 2'd1;
                                n_ao = 1'b1;
                            end
                        end
                    endcase
                end
                K_FU: begin
                    if (r_pos == 2'd1) begin
                        n_fu_end = b[6];
                        if (b[7]) begin
                            if (r_fu_open) begin
                                res[cnt[0]] = mk_nal(8'h00, 1'b0, 1'b0, 1'b0, 1'b1,
                                                     LANE_FRAG);
                                cnt = cnt + 2'd1;
                            end
                            n_fu_open = !(last && b[6]);
                            res[cnt[0]] = mk_nal({r_fu_ind, b[4:0]}, 1'b1, 1'b1,
                                                 last && b[6], 1'b0, LANE_FRAG);
                            cnt = cnt + 2'd1;
                        end else if (!r_fu_open) begin
                            n_kind = K_IGNORE;
                        end else if (last && b[6]) begin
                            res[cnt[0]] = mk_nal(8'h00, 1'b0, 1'b0, 1'b1, 1'b0,
                                                 LANE_FRAG);
                            cnt = cnt + 2'd1;
                            n_fu_open = 1'b0;
                        end
                    end else if (r_fu_open) begin
                        res[cnt[0]] = mk_nal(b, 1'b1, 1'b0, last && r_fu_end, 1'b0,
                                             LANE_FRAG);
                        cnt = cnt + 2'd1;
                        if (last && r_fu_end) begin
                            n_fu_open = 1'b0;
                        end
                    end
                end
                default: ;
            endcase
            if (r_pos < 2'd2) begin
                n_pos = r_pos + 2'd1;
            end
        end
        if (last) begin
            n_kind = K_IGNORE;
            n_ao   = 1'b0;
        end
    end

    assign o_push      = accept && (cnt != 2'd0);
    assign o_entry.two = cnt[1];
    assign o_entry.r0  = res[0];
    assign o_entry.r1  = res[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind    <= K_IGNORE;
            r_pos     <= 2'd0;
            r_fu_open <= 1'b0;
            r_fu_ind  <= 3'd0;
            r_fu_end  <= 1'b0;
            r_ph      <= PH_HI;
            r_rem     <= '0;
            r_ao      <= 1'b0;
        end else if (accept) begin
            r_kind    <= n_kind;
            r_pos     <= n_pos;
            r_fu_open <= n_fu_open;
            r_fu_ind  <= n_fu_ind;
            r_fu_end  <= n_fu_end;
            r_ph      <= n_ph;
            r_rem     <= n_rem;
            r_ao      <= n_ao;
        end
    end

endmodule

`default_nettype wire

>>> rtl/h264d_queue.sv
// ----------------------------------------------------------------------------
// H.264 RTP depacketizer entry queue
// Short FIFO of result entries between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module h264d_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire h264d_pkg::t_entry i_entry,
    output logic                   o_full,
    input  wire logic              i_pop,
    output h264d_pkg::t_entry      o_head,
    output logic                   o_empty
);
    import h264d_pkg::*;

    t_entry           r_mem [QDEPTH];
    logic [QAW-1:0]   r_wp, r_rp;
    logic [QAW:0]     r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == QAW'(0) + (QAW+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + QAW'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + QAW'(1);
            end
            r_cnt <= r_cnt + (QAW+1)'(do_push) - (QAW+1)'(do_pop);
        end
    end

endmodule

`default_nettype wire

>>> rtl/h264d_back.sv
// ----------------------------------------------------------------------------
// H.264 RTP depacketizer back end
// Drains queue entries one result at a time into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module h264d_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire h264d_pkg::t_entry i_head,
    input  wire logic              i_empty,
    output logic                   o_pop,
    h264d_out_if.source            o_out
);
    import h264d_pkg::*;

    logic r_ov, n_ov;
    logic r_sel, n_sel;
    t_nal r_od, n_od;
    logic ld;

    assign ld = !r_ov || o_out.ready;

    always_comb begin
        n_ov  = r_ov;
        n_sel = r_sel;
        n_od  = r_od;
        o_pop = 1'b0;
        if (ld) begin
            n_ov = !i_empty;
            if (!i_empty) begin
                n_od = r_sel ? i_head.r1 : i_head.r0;
                if (r_sel || !i_head.two) begin
                    o_pop = 1'b1;
                    n_sel = 1'b0;
                end else begin
                    n_sel = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_sel <= 1'b0;
        end else begin
            r_ov  <= n_ov;
            r_sel <= n_sel;
        end
        r_od <= n_od;
    end

    assign o_out.valid         = r_ov;
    assign o_out.nal_byte      = r_od.nal_byte;
    assign o_out.has_byte      = r_od.has_byte;
    assign o_out.nal_first     = r_od.nal_first;
    assign o_out.nal_last      = r_od.nal_last;
    assign o_out.nal_discard   = r_od.nal_discard;
    assign o_out.fragment_lane = r_od.fragment_lane;

endmodule

`default_nettype wire

>>> rtl/h264_rtp_depacketizer_unit.sv
// ----------------------------------------------------------------------------
// H.264 RTP depacketizer
// Splits RTP payload bytes into H.264 NAL byte streams with framing marks.
// Path: results go through the entry queue, then into the output register.
// Throughput: one payload byte per cycle while the queue is not full; a byte
//   yielding two results sends them out in turn, absorbed by a 4-entry queue.
// Reset: synchronous active-low clears framing state, queue and output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module h264_rtp_depacketizer_unit (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    h264d_in_if.sink     i_in,
    h264d_out_if.source  o_out
);
    import h264d_pkg::*;

    t_entry push_entry;
    t_entry head;
    logic   push, full, pop, empty;

    h264d_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_entry (push_entry),
        .o_push  (push)
    );

    h264d_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty)
    );

    h264d_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_empty (empty),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire
